// ===== rtl/hwe_pkg.sv =====
// ----------------------------------------------------------------------------
// hwe_pkg
// shared types and constants for the hardy-weinberg exact test block
// ----------------------------------------------------------------------------
package hwe_pkg;

  localparam int unsigned CountW = 13;
  localparam int unsigned ProbW  = 64;
  localparam int unsigned PvalW  = 33;
  localparam int unsigned ErrW   = 2;

  localparam logic [ErrW-1:0] ErrNone     = 2'd0;
  localparam logic [ErrW-1:0] ErrHetRare  = 2'd1;
  localparam logic [ErrW-1:0] ErrTotalMax = 2'd2;

  localparam logic [ProbW-1:0] OneQ44  = 64'h0000_1000_0000_0000;
  localparam logic [ProbW-1:0] OneQ32  = 64'h0000_0001_0000_0000;
  localparam logic [ProbW-1:0] HalfQ32 = 64'h0000_0000_8000_0000;
  localparam logic [ProbW-1:0] AllOnes = 64'hFFFF_FFFF_FFFF_FFFF;

  // request to the shared multiply-divide unit
  typedef struct packed {
    logic             start;
    logic [ProbW-1:0] a;
    logic [ProbW-1:0] b;
    logic [ProbW-1:0] c;
  } md_req_t;

  // answer from the shared multiply-divide unit
  typedef struct packed {
    logic             done;
    logic [ProbW-1:0] q;
  } md_rsp_t;

endpackage

// ===== rtl/hwe_if.sv =====
// ----------------------------------------------------------------------------
// hwe_in_if / hwe_out_if
// valid-ready channels carrying genotype counts in and a p-value out
// ----------------------------------------------------------------------------
interface hwe_in_if;
  logic                        valid;
  logic                        ready;
  logic [hwe_pkg::CountW-1:0]  obs_hom_a;
  logic [hwe_pkg::CountW-1:0]  obs_het;
  logic [hwe_pkg::CountW-1:0]  obs_hom_b;
  modport source (output valid, obs_hom_a, obs_het, obs_hom_b, input ready);
  modport sink   (input valid, obs_hom_a, obs_het, obs_hom_b, output ready);
endinterface

interface hwe_out_if;
  logic                       valid;
  logic                       ready;
  logic [hwe_pkg::PvalW-1:0]  p_value;
  logic [hwe_pkg::ErrW-1:0]   error_code;
  modport source (output valid, p_value, error_code, input ready);
  modport sink   (input valid, p_value, error_code, output ready);
endinterface

// ===== rtl/hwe_muldiv.sv =====
// ----------------------------------------------------------------------------
// hwe_muldiv
// floor(a*b/c) saturating to all ones; 32x32 partial products then a
// restoring divide one quotient bit per cycle
// ----------------------------------------------------------------------------
module hwe_muldiv (
  input  logic             clk_i,
  input  logic             rst_ni,
  input  hwe_pkg::md_req_t req_i,
  output hwe_pkg::md_rsp_t rsp_o
);

  typedef enum logic [4:0] {
    S_IDLE = 5'b00001,
    S_MUL  = 5'b00010,
    S_SUM  = 5'b00100,
    S_DIV  = 5'b01000,
    S_DONE = 5'b10000
  } md_state_e;

  md_state_e   state_q, state_d;
  logic [63:0] a_q, b_q, c_q;
  logic [63:0] p_q [4];
  logic [1:0]  pi_q, pi_d;
  logic [63:0] hi_q, hi_d, lo_q, lo_d, qt_q, qt_d;
  logic [6:0]  cnt_q, cnt_d;
  logic [63:0] prod;
  logic [31:0] ma, mb;
  logic [63:0] midw, lo_w, hi_w;
  logic [64:0] rem_sh;
  logic        ge;

  assign ma   = pi_q[1] ? a_q[63:32] : a_q[31:0];
  assign mb   = pi_q[0] ? b_q[63:32] : b_q[31:0];
  assign prod = {32'd0, ma} * {32'd0, mb};

  // p_q[0]=a0b0 [1]=a0b1 [2]=a1b0 [3]=a1b1
  assign midw = {32'd0, p_q[0][63:32]} + {32'd0, p_q[1][31:0]} + {32'd0, p_q[2][31:0]};
  assign lo_w = {midw[31:0], p_q[0][31:0]};
  assign hi_w = p_q[3] + {32'd0, p_q[1][63:32]} + {32'd0, p_q[2][63:32]}
              + {32'd0, midw[63:32]};

  assign rem_sh = {hi_q, lo_q[63]};
  assign ge     = rem_sh >= {1'b0, c_q};

  always_comb begin
    state_d = state_q;
    pi_d    = pi_q;
    hi_d    = hi_q;
    lo_d    = lo_q;
    qt_d    = qt_q;
    cnt_d   = cnt_q;
    case (state_q)
      S_IDLE: begin
        if (req_i.start) begin
          state_d = S_MUL;
          pi_d    = 2'd0;
        end
      end
      S_MUL: begin
        pi_d = pi_q + 2'd1;
        if (pi_q == 2'd3) state_d = S_SUM;
      end
      S_SUM: begin
        hi_d  = hi_w;
        lo_d  = lo_w;
        qt_d  = '0;
        cnt_d = '0;
        if (c_q == '0 || hi_w >= c_q) begin
          qt_d    = hwe_pkg::AllOnes;
          state_d = S_DONE;
        end else begin
          state_d = S_DIV;
        end
      end
      S_DIV: begin
        lo_d  = {lo_q[62:0], 1'b0};
        hi_d  = ge ? 64'(rem_sh - {1'b0, c_q}) : rem_sh[63:0];
        qt_d  = {qt_q[62:0], ge};
        cnt_d = cnt_q + 7'd1;
        if (cnt_q == 7'd63) state_d = S_DONE;
      end
      S_DONE:  state_d = S_IDLE;
      default: state_d = S_IDLE;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= S_IDLE;
      pi_q    <= '0;
      cnt_q   <= '0;
    end else begin
      state_q <= state_d;
      pi_q    <= pi_d;
      cnt_q   <= cnt_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (state_q == S_IDLE && req_i.start) begin
      a_q <= req_i.a;
      b_q <= req_i.b;
      c_q <= req_i.c;
    end
    if (state_q == S_MUL) p_q[pi_q] <= prod;
    hi_q <= hi_d;
    lo_q <= lo_d;
    qt_q <= qt_d;
  end

  assign rsp_o.done = state_q == S_DONE;
  assign rsp_o.q    = qt_q;

endmodule

// ===== rtl/hwe_store.sv =====
// ----------------------------------------------------------------------------
// hwe_store
// single-port probability memory, registered read
// ----------------------------------------------------------------------------
module hwe_store #(
  parameter int unsigned Depth = 4097,
  parameter int unsigned AddrW = 13
) (
  input  logic                      clk_i,
  input  logic                      we_i,
  input  logic [AddrW-1:0]          addr_i,
  input  logic [hwe_pkg::ProbW-1:0] wdata_i,
  output logic [hwe_pkg::ProbW-1:0] rdata_o
);

  logic [hwe_pkg::ProbW-1:0] mem_q [Depth];

  always_ff @(posedge clk_i) begin
    if (we_i) mem_q[addr_i] <= wdata_i;
    rdata_o <= mem_q[addr_i];
  end

endmodule

// ===== rtl/hardy_weinberg_exact_pvalue.sv =====
// ----------------------------------------------------------------------------
// hardy_weinberg_exact_pvalue
// exact two-sided hardy-weinberg p-value from three genotype counts
// ----------------------------------------------------------------------------
// channel  dir  word fields
// in_i     in   obs_hom_a, obs_het, obs_hom_b (13 bits each)
// out_o    out  p_value (33 bits, q1.32), error_code (2 bits)
//
// one word at a time: ready is high only while idle and no result is held
// each recurrence step and each normalize step is a memory read plus one pass
// through the shared multiply-divide unit; an item of rare allele count r takes
// r/2 recurrence steps and r+1 normalize steps, then a read-and-add sum per
// entry, after one multiply-divide pass for the midpoint
// error and empty words finish in the check state; reset clears control only
// the result register holds until the sink takes it
// ----------------------------------------------------------------------------
module hardy_weinberg_exact_pvalue #(
  parameter int unsigned MAX_GENOTYPES = 4096
) (
  input  logic         clk_i,
  input  logic         rst_ni,
  hwe_in_if.sink       in_i,
  hwe_out_if.source    out_o
);

  localparam int unsigned Depth = MAX_GENOTYPES + 1;
  localparam int unsigned AddrW = $clog2(Depth);
  // counts up to 2*max, and never narrower than the sum of three raw counts
  localparam int unsigned NW    =
    ($clog2(2 * MAX_GENOTYPES + 1) + 1 > hwe_pkg::CountW + 2) ?
    $clog2(2 * MAX_GENOTYPES + 1) + 1 : hwe_pkg::CountW + 2;

  typedef enum logic [13:0] {
    S_IDLE  = 14'b00000000000001,
    S_CHECK = 14'b00000000000010,
    S_MIDM  = 14'b00000000000100,
    S_MIDW  = 14'b00000000001000,
    S_SEED  = 14'b00000000010000,
    S_DRD   = 14'b00000000100000,
    S_DMD   = 14'b00000001000000,
    S_URD   = 14'b00000010000000,
    S_UMD   = 14'b00000100000000,
    S_NRD   = 14'b00001000000000,
    S_NMD   = 14'b00010000000000,
    S_SRD   = 14'b00100000000000,
    S_SACC  = 14'b01000000000000,
    S_FIN   = 14'b10000000000000
  } st_e;

  st_e                        state_q, state_d;
  logic [NW-1:0]              n_q, rare_q, het_q, mid_q, h_q, hr_q, hc_q, z_q;
  logic [63:0]                sum_q, top_q, oth_q;
  logic                       oval_q;
  logic [hwe_pkg::PvalW-1:0]  pval_q;
  logic [hwe_pkg::ErrW-1:0]   err_q;
  hwe_pkg::md_req_t           md_req;
  hwe_pkg::md_rsp_t           md_rsp;
  logic                       we;
  logic [AddrW-1:0]           addr;
  logic [63:0]                wdata, rdata;
  logic                       acc;
  logic [NW-1:0]              allele, nsum;
  logic [63:0]                sum_add, two_m, minv;
  logic                       zero_par;

  assign acc = in_i.valid && in_i.ready;
  assign in_i.ready = (state_q == S_IDLE) && !oval_q;

  assign nsum   = NW'(in_i.obs_hom_a) + NW'(in_i.obs_het) + NW'(in_i.obs_hom_b);
  assign allele = NW'({in_i.obs_hom_a, 1'b0}) + NW'(in_i.obs_het);

  hwe_muldiv u_md (.clk_i(clk_i), .rst_ni(rst_ni), .req_i(md_req), .rsp_o(md_rsp));

  hwe_store #(.Depth(Depth), .AddrW(AddrW)) u_store (
    .clk_i(clk_i), .we_i(we), .addr_i(addr), .wdata_i(wdata), .rdata_o(rdata)
  );

  // midpoint: rare*(2n-rare) then divide by 2n, done through the shared unit
  // with a=rare, b=2n-rare, c=2n
  logic [NW-1:0] mid_raw;
  assign mid_raw  = NW'(md_rsp.q);
  assign sum_add  = (sum_q + md_rsp.q < sum_q) ? hwe_pkg::AllOnes : sum_q + md_rsp.q;
  // entries of opposite parity to rare are zero
  assign zero_par = z_q[0] != rare_q[0];

  always_comb begin
    state_d    = state_q;
    md_req     = '0;
    we         = 1'b0;
    addr       = AddrW'(h_q);
    wdata      = md_rsp.q;
    case (state_q)
      S_IDLE:  if (acc) state_d = S_CHECK;
      S_CHECK: state_d = S_MIDM;
      S_MIDM: begin
        md_req.start = 1'b1;
        md_req.a = 64'(rare_q);
        md_req.b = 64'({n_q, 1'b0} - rare_q);
        md_req.c = 64'({n_q, 1'b0});
        state_d  = S_MIDW;
      end
      S_MIDW:  if (md_rsp.done) state_d = S_SEED;
      S_SEED: begin
        we      = 1'b1;
        addr    = AddrW'(mid_q);
        wdata   = hwe_pkg::OneQ44;
        state_d = (mid_q > NW'(1)) ? S_DRD : S_URD;
      end
      S_DRD: state_d = S_DMD;
      S_DMD: begin
        md_req.start = 1'b1;
        md_req.a = rdata;
        md_req.b = 64'(h_q) * 64'(h_q - NW'(1));
        md_req.c = 64'({hr_q + NW'(1), 2'b00}) * 64'(hc_q + NW'(1));
        state_d  = S_DMD;
        if (md_rsp.done) begin
          we   = 1'b1;
          addr = AddrW'(h_q - NW'(2));
        end
      end
      S_URD: state_d = S_UMD;
      S_UMD: begin
        md_req.start = 1'b1;
        md_req.a = rdata;
        md_req.b = 64'({hr_q, 2'b00}) * 64'(hc_q);
        md_req.c = 64'(h_q + NW'(2)) * 64'(h_q + NW'(1));
        if (md_rsp.done) begin
          we   = 1'b1;
          addr = AddrW'(h_q + NW'(2));
        end
      end
      S_NRD: begin
        addr = AddrW'(z_q);
        state_d = S_NMD;
      end
      S_NMD: begin
        addr = AddrW'(z_q);
        md_req.start = 1'b1;
        md_req.a = zero_par ? 64'd0 : rdata;
        md_req.b = hwe_pkg::OneQ32;
        md_req.c = sum_q;
        if (md_rsp.done) we = 1'b1;
      end
      S_SRD: begin
        addr = AddrW'(z_q);
        state_d = S_SACC;
      end
      S_SACC: addr = AddrW'(z_q);
      S_FIN:  state_d = S_IDLE;
      default: state_d = S_IDLE;
    endcase
  end

  assign minv  = (top_q < oth_q) ? top_q : oth_q;
  assign two_m = {minv[62:0], 1'b0};

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= S_IDLE;
      oval_q  <= 1'b0;
    end else begin
      if (out_o.valid && out_o.ready) oval_q <= 1'b0;
      case (state_q)
        S_IDLE:  if (acc) state_q <= S_CHECK;
        S_CHECK: begin
          if (n_q > NW'(MAX_GENOTYPES) || n_q == '0 || het_q > rare_q) begin
            state_q <= S_IDLE;
            oval_q  <= 1'b1;
          end else begin
            state_q <= S_MIDM;
          end
        end
        S_MIDW: if (md_rsp.done) state_q <= S_SEED;
        S_DMD: begin
          if (md_rsp.done) state_q <= (h_q - NW'(2) > NW'(1)) ? S_DRD : S_URD;
        end
        S_UMD: begin
          if (md_rsp.done) state_q <= (h_q + NW'(4) <= rare_q) ? S_URD : S_NRD;
        end
        S_SEED: begin
          state_q <= state_d;
          if (!(mid_q > NW'(1)) && !(mid_q + NW'(2) <= rare_q)) state_q <= S_NRD;
        end
        S_URD: begin
          state_q <= S_UMD;
          if (!(h_q + NW'(2) <= rare_q)) state_q <= S_NRD;
        end
        S_NMD: if (md_rsp.done) state_q <= (z_q == rare_q) ? S_SRD : S_NRD;
        S_SACC: state_q <= (z_q == rare_q) ? S_FIN : S_SRD;
        S_FIN: begin
          state_q <= S_IDLE;
          oval_q  <= 1'b1;
        end
        default: state_q <= state_d;
      endcase
    end
  end

  // datapath registers
  always_ff @(posedge clk_i) begin
    case (state_q)
      S_IDLE: begin
        if (acc) begin
          n_q    <= nsum;
          het_q  <= NW'(in_i.obs_het);
          rare_q <= (allele > nsum) ? NW'({nsum, 1'b0} - allele) : allele;
        end
      end
      S_CHECK: begin
        pval_q <= '0;
        err_q  <= hwe_pkg::ErrNone;
        if (n_q > NW'(MAX_GENOTYPES)) err_q <= hwe_pkg::ErrTotalMax;
        else if (n_q != '0 && het_q > rare_q) err_q <= hwe_pkg::ErrHetRare;
      end
      S_MIDW: begin
        if (md_rsp.done) begin
          mid_q <= (mid_raw[0] != rare_q[0]) ? mid_raw + NW'(1) : mid_raw;
        end
      end
      S_SEED: begin
        sum_q <= hwe_pkg::OneQ44;
        h_q   <= mid_q;
        hr_q  <= (rare_q - mid_q) >> 1;
        hc_q  <= n_q - mid_q - ((rare_q - mid_q) >> 1);
        z_q   <= '0;
        if (!(mid_q > NW'(1))) h_q <= mid_q;
      end
      S_DMD: begin
        if (md_rsp.done) begin
          sum_q <= sum_add;
          if (h_q - NW'(2) > NW'(1)) begin
            h_q  <= h_q - NW'(2);
            hr_q <= hr_q + NW'(1);
            hc_q <= hc_q + NW'(1);
          end else begin
            h_q  <= mid_q;
            hr_q <= (rare_q - mid_q) >> 1;
            hc_q <= n_q - mid_q - ((rare_q - mid_q) >> 1);
          end
        end
      end
      S_UMD: begin
        if (md_rsp.done) begin
          sum_q <= sum_add;
          h_q   <= h_q + NW'(2);
          hr_q  <= hr_q - NW'(1);
          hc_q  <= hc_q - NW'(1);
        end
      end
      S_NMD: begin
        if (md_rsp.done) begin
          if (z_q == rare_q) begin
            z_q   <= '0;
            top_q <= '0;
            oth_q <= '0;
          end else begin
            z_q <= z_q + NW'(1);
          end
        end
      end
      S_SACC: begin
        if (z_q >= het_q) top_q <= top_q + rdata;
        if (z_q <= het_q) oth_q <= oth_q + rdata;
        z_q <= z_q + NW'(1);
      end
      S_FIN: begin
        err_q <= hwe_pkg::ErrNone;
        if (top_q > hwe_pkg::HalfQ32 && oth_q > hwe_pkg::HalfQ32) begin
          pval_q <= hwe_pkg::PvalW'(hwe_pkg::OneQ32);
        end else if (minv >= hwe_pkg::HalfQ32) begin
          pval_q <= hwe_pkg::PvalW'(hwe_pkg::OneQ32);
        end else begin
          pval_q <= two_m[hwe_pkg::PvalW-1:0];
        end
      end
      default: ;
    endcase
  end

  assign out_o.valid      = oval_q;
  assign out_o.p_value    = pval_q;
  assign out_o.error_code = err_q;

`ifndef SYNTHESIS
  // no new word is taken while a result is still waiting
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_o.valid && !out_o.ready |=> !(in_i.valid && in_i.ready) || out_o.valid == 1'b0)
    else $error("word accepted over pending result");
  // p-value never exceeds one
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_o.valid |-> out_o.p_value <= hwe_pkg::PvalW'(hwe_pkg::OneQ32))
    else $error("p-value above one");
  // an error result carries a zero p-value
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_o.valid && out_o.error_code != hwe_pkg::ErrNone |-> out_o.p_value == '0)
    else $error("error result with nonzero p-value");
`endif

endmodule

// ===== tb/testbench.sv =====
// ----------------------------------------------------------------------------
// testbench
// checks the hardy-weinberg exact p-value block one word at a time: a
// scoreboard predicts every result from the three genotype counts it sees
// accepted, and random idling plus one long hold-off on the result side
// exercise the valid-ready flow of both channels
// ----------------------------------------------------------------------------
module testbench;
  timeunit 1ns;
  timeprecision 1ps;

  typedef struct {
    logic [hwe_pkg::PvalW-1:0] p_value;
    logic [hwe_pkg::ErrW-1:0]  error_code;
  } hwe_result_t;

  // predicts each p-value and holds the ones still owed by the block
  class hwe_scoreboard;
    hwe_result_t               owed_q[$];
    int                        mismatches;
    logic [hwe_pkg::ProbW-1:0] het_prob [0:4096];

    task report(string what, logic [63:0] got, logic [63:0] want);
      $display("mismatch %s: got %0d want %0d", what, got, want);
      mismatches++;
    endtask

    // floor(a*b/c) from the exact product, saturating to all ones
    function logic [hwe_pkg::ProbW-1:0] scaled_ratio(logic [63:0] a, logic [63:0] b,
                                                     logic [63:0] c);
      logic [127:0] prod;
      logic [127:0] quot;
      prod = {64'd0, a} * {64'd0, b};
      if (c == 0 || prod[127:64] >= c) return hwe_pkg::AllOnes;
      quot = prod / {64'd0, c};
      return quot[63:0];
    endfunction

    function hwe_result_t exact_pvalue(logic [hwe_pkg::CountW-1:0] aa,
                                       logic [hwe_pkg::CountW-1:0] ab,
                                       logic [hwe_pkg::CountW-1:0] bb);
      hwe_result_t res;
      logic [63:0] n, allele, rare, mid, h, hom_r, hom_c, total, top, other, m, v;
      logic [64:0] wide;
      res.p_value    = '0;
      res.error_code = hwe_pkg::ErrNone;
      n      = 64'(aa) + 64'(ab) + 64'(bb);
      allele = 2 * 64'(aa) + 64'(ab);
      if (n > 4096) begin
        res.error_code = hwe_pkg::ErrTotalMax;
        return res;
      end
      if (n == 0) return res;
      rare = (allele > n) ? 2 * n - allele : allele;
      if (64'(ab) > rare) begin
        res.error_code = hwe_pkg::ErrHetRare;
        return res;
      end
      for (int z = 0; z <= rare; z++) het_prob[z] = '0;
      // start at the expected het count, matched to the parity of rare
      mid = (rare * (2 * n - rare)) / (2 * n);
      if ((rare[0] ^ mid[0]) != 1'b0) mid++;
      het_prob[mid] = hwe_pkg::OneQ44;
      total = hwe_pkg::OneQ44;
      hom_r = (rare - mid) / 2;
      hom_c = n - mid - hom_r;
      for (h = mid; h > 1; h -= 2) begin
        v = scaled_ratio(het_prob[h], h * (h - 1), 4 * (hom_r + 1) * (hom_c + 1));
        het_prob[h - 2] = v;
        wide  = {1'b0, total} + {1'b0, v};
        total = wide[64] ? hwe_pkg::AllOnes : wide[63:0];
        hom_r++;
        hom_c++;
      end
      hom_r = (rare - mid) / 2;
      hom_c = n - mid - hom_r;
      for (h = mid; h + 2 <= rare; h += 2) begin
        v = scaled_ratio(het_prob[h], 4 * hom_r * hom_c, (h + 2) * (h + 1));
        het_prob[h + 2] = v;
        wide  = {1'b0, total} + {1'b0, v};
        total = wide[64] ? hwe_pkg::AllOnes : wide[63:0];
        hom_r--;
        hom_c--;
      end
      for (int z = 0; z <= rare; z++)
        het_prob[z] = scaled_ratio(het_prob[z], hwe_pkg::OneQ32, total);
      top = 0;
      for (int z = ab; z <= rare; z++) top += het_prob[z];
      other = 0;
      for (int z = 0; z <= ab; z++) other += het_prob[z];
      if (top > hwe_pkg::HalfQ32 && other > hwe_pkg::HalfQ32) begin
        res.p_value = hwe_pkg::OneQ32[hwe_pkg::PvalW-1:0];
      end else begin
        m = (top < other) ? top : other;
        res.p_value = (m >= hwe_pkg::HalfQ32) ? hwe_pkg::OneQ32[hwe_pkg::PvalW-1:0]
                                              : hwe_pkg::PvalW'(2 * m);
      end
      return res;
    endfunction

    function void note_counts(logic [hwe_pkg::CountW-1:0] aa,
                              logic [hwe_pkg::CountW-1:0] ab,
                              logic [hwe_pkg::CountW-1:0] bb);
      owed_q.push_back(exact_pvalue(aa, ab, bb));
    endfunction

    task check_result(logic [hwe_pkg::PvalW-1:0] pv, logic [hwe_pkg::ErrW-1:0] err);
      hwe_result_t want;
      if (owed_q.size() == 0) begin
        report("unexpected result word, p_value", 64'(pv), 64'd0);
        return;
      end
      want = owed_q.pop_front();
      if (pv !== want.p_value) report("p_value", 64'(pv), 64'(want.p_value));
      if (err !== want.error_code) report("error_code", 64'(err), 64'(want.error_code));
    endtask
  endclass

  logic clk_i;
  logic rst_ni;
  logic counts_done;

  hwe_in_if  in_if ();
  hwe_out_if out_if ();

  hardy_weinberg_exact_pvalue u_dut (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .in_i   (in_if.sink),
    .out_o  (out_if.source)
  );

  hwe_scoreboard hwe_sb = new();

  initial begin
    clk_i = 1'b0;
    forever #5 clk_i = ~clk_i;
  end

  // hand one genotype word to the block after the given idle gap
  task automatic send_counts(input logic [hwe_pkg::CountW-1:0] aa,
                             input logic [hwe_pkg::CountW-1:0] ab,
                             input logic [hwe_pkg::CountW-1:0] bb, input int gap);
    if (gap > 0) begin
      in_if.valid <= 1'b0;
      repeat (gap) @(posedge clk_i);
    end
    in_if.valid     <= 1'b1;
    in_if.obs_hom_a <= aa;
    in_if.obs_het   <= ab;
    in_if.obs_hom_b <= bb;
    do @(posedge clk_i); while (!(in_if.valid && in_if.ready));
    hwe_sb.note_counts(aa, ab, bb);
  endtask

  // one random sample: mostly small populations so the recurrence stays short
  task automatic send_random(input int idx);
    logic [hwe_pkg::CountW-1:0] aa, ab, bb;
    int n, sel, gap;
    sel = $urandom_range(0, 99);
    gap = (idx % 20 < 5) ? 0 : $urandom_range(0, 11);
    if (sel < 12) begin
      // raw words, nearly always over the maximum; toggles every input bit
      aa = hwe_pkg::CountW'($urandom);
      ab = hwe_pkg::CountW'($urandom);
      bb = hwe_pkg::CountW'($urandom);
    end else begin
      n  = (sel < 16) ? $urandom_range(60, 200) : $urandom_range(0, 24);
      aa = hwe_pkg::CountW'($urandom_range(0, n));
      ab = hwe_pkg::CountW'($urandom_range(0, n - aa));
      bb = hwe_pkg::CountW'(n - aa - ab);
    end
    send_counts(aa, ab, bb, gap);
  endtask

  // sender: directed corners first, then random samples
  initial begin
    counts_done      = 1'b0;
    in_if.valid     <= 1'b0;
    in_if.obs_hom_a <= '0;
    in_if.obs_het   <= '0;
    in_if.obs_hom_b <= '0;
    rst_ni = 1'b0;
    repeat (9) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);
    send_counts(13'd0, 13'd0, 13'd0, 0);            // empty sample
    send_counts(13'd4097, 13'd0, 13'd0, 0);         // one above the maximum
    send_counts(13'd0, 13'd0, 13'd4097, 1);
    send_counts(13'd0, 13'd4097, 13'd0, 0);
    send_counts(13'd8191, 13'd8191, 13'd8191, 2);   // every count at full scale
    send_counts(13'd4096, 13'd0, 13'd0, 0);         // full population, no rare allele
    send_counts(13'd0, 13'd0, 13'd4096, 3);
    send_counts(13'd4094, 13'd2, 13'd0, 0);
    send_counts(13'd4000, 13'd50, 13'd46, 0);       // full population with a real recurrence
    send_counts(13'd1, 13'd0, 13'd0, 0);
    send_counts(13'd0, 13'd1, 13'd0, 1);
    send_counts(13'd0, 13'd0, 13'd1, 0);
    send_counts(13'd1, 13'd1, 13'd1, 0);
    send_counts(13'd5, 13'd0, 13'd5, 4);            // no hets at all
    send_counts(13'd0, 13'd10, 13'd0, 0);           // only hets
    send_counts(13'd3, 13'd4, 13'd3, 0);
    send_counts(13'd7, 13'd1, 13'd12, 11);
    send_counts(13'd2, 13'd9, 13'd0, 0);
    for (int i = 0; i < 100; i++) send_random(i);
    in_if.valid <= 1'b0;
    counts_done  = 1'b1;
  end

  // receiver: a long hold-off first so the block fills and stalls its input
  initial begin
    int stall;
    int cnt;
    out_if.ready <= 1'b0;
    @(posedge rst_ni);
    cnt = 0;
    while (cnt < 2500) begin
      @(posedge clk_i);
      cnt++;
    end
    forever begin
      stall = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(0, 11);
      if (stall > 0) begin
        out_if.ready <= 1'b0;
        repeat (stall) @(posedge clk_i);
      end
      out_if.ready <= 1'b1;
      do @(posedge clk_i); while (!(out_if.valid && out_if.ready));
      hwe_sb.check_result(out_if.p_value, out_if.error_code);
    end
  end

  // end of run: drain, then allow the block a little more time
  initial begin
    wait (counts_done === 1'b1);
    while (hwe_sb.owed_q.size() != 0) @(posedge clk_i);
    repeat (300) @(posedge clk_i);
    if (hwe_sb.owed_q.size() != 0) begin
      hwe_sb.report("results never delivered", 64'(hwe_sb.owed_q.size()), 64'd0);
    end
    if (hwe_sb.mismatches == 0) begin
      $display("tb: success");
    end else begin
      $display("tb: failure");
    end
    $finish;
  end

  // watchdog
  initial begin
    #50_000_000;
    $display("tb: failure");
    $finish;
  end

endmodule
